// File: sv/rrp_pkg.sv
// Shared types and constants of the request parser.
package rrp_pkg;

  localparam int COUNT_WIDTH  = 16;
  localparam int LENGTH_WIDTH = 32;
  localparam int MAG_WIDTH    = LENGTH_WIDTH + 4;

  localparam logic [15:0] MAX_ARGS_RST = 16'd1024;
  localparam logic [31:0] MAX_BULK_RST = 32'd536870912;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [0:0] {
    CFG_MAX_ARGS = 1'b0,
    CFG_MAX_BULK = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    KIND_BYTE   = 1'b0,
    KIND_RESYNC = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    PH_ARRAY    = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_BULK     = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_DATA_CR  = 4'd7,
    PH_DATA_LF  = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ERR_ARRAY  = 3'd0,
    ERR_COUNT  = 3'd1,
    ERR_BULK   = 3'd2,
    ERR_LENGTH = 3'd3,
    ERR_TERM   = 3'd4
  } err_code_t;

endpackage

// File: sv/resp_request_parser_core.sv
// Byte-serial parser for requests framed as an array of bulk strings.
//
// One beat in, one beat out: every accepted byte (or resync) produces exactly
// one result beat. A beat is taken into an input register, decoded by the
// per-byte state machine with its one decimal accumulate step, and the result
// lands in an output register, so the block sustains one byte per cycle as long
// as out_ready is high; in_ready falls only while both registers are full and
// out_ready is low. Errors are flagged on the byte where they become certain
// and are held (all-zero results) until a resync beat. Write cfg_* only while
// the block is idle.
module resp_request_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [7:0]                    in_stream_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_payload_valid,
  output logic [7:0]                    out_payload_byte,
  output logic [15:0]                   out_argument_number,
  output logic                          out_argument_done,
  output logic [31:0]                   out_argument_length,
  output logic                          out_command_done,
  output logic [15:0]                   out_argument_total,
  output logic                          out_error_flag,
  output logic [2:0]                    out_error_code
);
  import rrp_pkg::*;

  // configuration
  logic [COUNT_WIDTH-1:0]  max_args_r;
  logic [LENGTH_WIDTH-1:0] max_bulk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r <= MAX_ARGS_RST[COUNT_WIDTH-1:0];
      max_bulk_r <= MAX_BULK_RST[LENGTH_WIDTH-1:0];
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_ARGS: max_args_r <= cfg_wdata[COUNT_WIDTH-1:0];
        CFG_MAX_BULK: max_bulk_r <= cfg_wdata[LENGTH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_v_r;
  logic       in_kind_r;
  logic [7:0] in_byte_r;
  logic       step;

  assign step     = in_v_r && (!out_valid || out_ready);
  assign in_ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_kind_r <= in_kind;
      in_byte_r <= in_stream_byte;
    end
  end

  // parser state
  phase_t                  phase_r, phase_nxt;
  logic [LENGTH_WIDTH-1:0] mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic                    has_dig_r, has_dig_nxt;
  logic [COUNT_WIDTH-1:0]  args_exp_r, args_exp_nxt;
  logic [COUNT_WIDTH-1:0]  args_rcv_r, args_rcv_nxt;
  logic [LENGTH_WIDTH-1:0] remain_r, remain_nxt;
  logic [LENGTH_WIDTH-1:0] cur_len_r, cur_len_nxt;
  logic                    hold_r, hold_nxt;

  // result
  logic        pv_nxt, ad_nxt, cd_nxt, ef_nxt;
  logic [7:0]  pb_nxt;
  logic [15:0] an_nxt, at_nxt;
  logic [31:0] al_nxt;
  err_code_t   ec_nxt;

  // number datapath
  logic                    is_digit;
  logic [3:0]              digit;
  logic [MAG_WIDTH-1:0]    acc;
  logic [COUNT_WIDTH-1:0]  args_inc;
  logic                    cnt_num_err, len_num_err;

  always_comb begin
    is_digit = (in_byte_r >= CH_ZERO) && (in_byte_r <= CH_NINE);
    digit    = in_byte_r[3:0];
    acc      = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1)
               + {{(MAG_WIDTH-4){1'b0}}, digit};
    args_inc = args_rcv_r + 1'b1;
    // counts never take a sign
    cnt_num_err = !is_digit
                  || (acc > {{(MAG_WIDTH-COUNT_WIDTH){1'b0}}, max_args_r});
    if (in_byte_r == CH_MINUS) begin
      len_num_err = neg_r || has_dig_r;
    end else begin
      len_num_err = !is_digit || (neg_r && digit != 4'd0)
                    || (acc > {4'd0, max_bulk_r});
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    has_dig_nxt  = has_dig_r;
    args_exp_nxt = args_exp_r;
    args_rcv_nxt = args_rcv_r;
    remain_nxt   = remain_r;
    cur_len_nxt  = cur_len_r;
    hold_nxt     = hold_r;
    pv_nxt = 1'b0;
    pb_nxt = 8'd0;
    an_nxt = 16'd0;
    ad_nxt = 1'b0;
    al_nxt = 32'd0;
    cd_nxt = 1'b0;
    at_nxt = 16'd0;
    ef_nxt = 1'b0;
    ec_nxt = ERR_ARRAY;

    if (kind_t'(in_kind_r) == KIND_RESYNC) begin
      phase_nxt    = PH_ARRAY;
      mag_nxt      = '0;
      neg_nxt      = 1'b0;
      has_dig_nxt  = 1'b0;
      args_exp_nxt = '0;
      args_rcv_nxt = '0;
      remain_nxt   = '0;
      cur_len_nxt  = '0;
      hold_nxt     = 1'b0;
    end else if (!hold_r) begin
      an_nxt = 16'(args_rcv_r);
      unique case (phase_r)
        PH_ARRAY: begin
          if (in_byte_r == CH_STAR) begin
            mag_nxt     = '0;
            neg_nxt     = 1'b0;
            has_dig_nxt = 1'b0;
            phase_nxt   = PH_COUNT;
          end else begin
            ef_nxt = 1'b1;
            ec_nxt = ERR_ARRAY;
          end
        end
        PH_COUNT: begin
          if (in_byte_r == CH_CR) begin
            if (!has_dig_r || mag_r == '0) begin
              ef_nxt = 1'b1;
              ec_nxt = ERR_COUNT;
            end else begin
              phase_nxt = PH_COUNT_LF;
            end
          end else if (cnt_num_err) begin
            ef_nxt = 1'b1;
            ec_nxt = ERR_COUNT;
          end else begin
            mag_nxt     = acc[LENGTH_WIDTH-1:0];
            has_dig_nxt = 1'b1;
          end
        end
        PH_COUNT_LF: begin
          if (in_byte_r == CH_LF) begin
            args_exp_nxt = mag_r[COUNT_WIDTH-1:0];
            args_rcv_nxt = '0;
            phase_nxt    = PH_BULK;
          end else begin
            ef_nxt = 1'b1;
            ec_nxt = ERR_COUNT;
          end
        end
        PH_BULK: begin
          if (in_byte_r == CH_DOLLAR) begin
            mag_nxt     = '0;
            neg_nxt     = 1'b0;
            has_dig_nxt = 1'b0;
            phase_nxt   = PH_LEN;
          end else begin
            ef_nxt = 1'b1;
            ec_nxt = ERR_BULK;
          end
        end
        PH_LEN: begin
          if (in_byte_r == CH_CR) begin
            if (!has_dig_r) begin
              ef_nxt = 1'b1;
              ec_nxt = ERR_LENGTH;
            end else begin
              phase_nxt = PH_LEN_LF;
            end
          end else if (len_num_err) begin
            ef_nxt = 1'b1;
            ec_nxt = ERR_LENGTH;
          end else if (in_byte_r == CH_MINUS) begin
            neg_nxt = 1'b1;
          end else begin
            mag_nxt     = acc[LENGTH_WIDTH-1:0];
            has_dig_nxt = 1'b1;
          end
        end
        PH_LEN_LF: begin
          if (in_byte_r == CH_LF) begin
            cur_len_nxt = mag_r;
            remain_nxt  = mag_r;
            phase_nxt   = (mag_r == '0) ? PH_DATA_CR : PH_DATA;
          end else begin
            ef_nxt = 1'b1;
            ec_nxt = ERR_LENGTH;
          end
        end
        PH_DATA: begin
          pv_nxt     = 1'b1;
          pb_nxt     = in_byte_r;
          remain_nxt = remain_r - 1'b1;
          if (remain_r == LENGTH_WIDTH'(1)) begin
            phase_nxt = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (in_byte_r == CH_CR) begin
            phase_nxt = PH_DATA_LF;
          end else begin
            ef_nxt = 1'b1;
            ec_nxt = ERR_TERM;
          end
        end
        PH_DATA_LF: begin
          if (in_byte_r == CH_LF) begin
            ad_nxt       = 1'b1;
            al_nxt       = 32'(cur_len_r);
            args_rcv_nxt = args_inc;
            if (args_inc == args_exp_r) begin
              cd_nxt       = 1'b1;
              at_nxt       = 16'(args_exp_r);
              // request complete: back to the array marker
              phase_nxt    = PH_ARRAY;
              mag_nxt      = '0;
              neg_nxt      = 1'b0;
              has_dig_nxt  = 1'b0;
              args_exp_nxt = '0;
              args_rcv_nxt = '0;
              remain_nxt   = '0;
              cur_len_nxt  = '0;
            end else begin
              phase_nxt = PH_BULK;
            end
          end else begin
            ef_nxt = 1'b1;
            ec_nxt = ERR_TERM;
          end
        end
        default: begin
          ef_nxt = 1'b1;
          ec_nxt = ERR_ARRAY;
        end
      endcase
      if (ef_nxt) begin
        hold_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ARRAY;
      mag_r      <= '0;
      neg_r      <= 1'b0;
      has_dig_r  <= 1'b0;
      args_exp_r <= '0;
      args_rcv_r <= '0;
      remain_r   <= '0;
      cur_len_r  <= '0;
      hold_r     <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      mag_r      <= mag_nxt;
      neg_r      <= neg_nxt;
      has_dig_r  <= has_dig_nxt;
      args_exp_r <= args_exp_nxt;
      args_rcv_r <= args_rcv_nxt;
      remain_r   <= remain_nxt;
      cur_len_r  <= cur_len_nxt;
      hold_r     <= hold_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_payload_valid   <= pv_nxt;
      out_payload_byte    <= pb_nxt;
      out_argument_number <= an_nxt;
      out_argument_done   <= ad_nxt;
      out_argument_length <= al_nxt;
      out_command_done    <= cd_nxt;
      out_argument_total  <= at_nxt;
      out_error_flag      <= ef_nxt;
      out_error_code      <= ef_nxt ? ec_nxt : ERR_ARRAY;
    end
  end

endmodule

// File: verif/resp_request_parser_core_tb.sv
// Self-checking testbench of the request parser core: byte stream in, one report beat out.
`timescale 1ns / 100ps

module resp_request_parser_core_tb;
  import rrp_pkg::*;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] argument_number;
    logic        argument_done;
    logic [31:0] argument_length;
    logic        command_done;
    logic [15:0] argument_total;
    logic        error_flag;
    err_code_t   error_code;
  } byte_report_t;

  // Tracks the parser state per accepted beat and holds the reports still owed.
  class parse_scoreboard;
    phase_t       phase;
    logic [63:0]  magnitude;
    bit           negative;
    bit           has_digit;
    logic [15:0]  args_expected;
    logic [15:0]  args_received;
    logic [31:0]  remaining;
    logic [31:0]  cur_length;
    bit           held;
    logic [15:0]  max_args;
    logic [31:0]  max_bulk;
    byte_report_t awaited_reports[$];
    int unsigned  live_beats;
    int unsigned  failures;

    function void clear_number();
      magnitude = '0;
      negative  = 1'b0;
      has_digit = 1'b0;
    endfunction

    function void clear_request();
      phase = PH_ARRAY;
      clear_number();
      args_expected = '0;
      args_received = '0;
      remaining     = '0;
      cur_length    = '0;
    endfunction

    function void power_on();
      max_args = MAX_ARGS_RST;
      max_bulk = MAX_BULK_RST;
      clear_request();
      held = 1'b0;
      awaited_reports.delete();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] value);
      if (idx == CFG_MAX_ARGS) max_args = value[15:0];
      else max_bulk = value;
    endfunction

    // Accumulate one number character; return 1 once the number is certainly bad.
    function bit number_char_bad(logic [7:0] b, bit is_count, logic [63:0] limit);
      if (b == CH_MINUS) begin
        if (is_count || negative || has_digit) return 1'b1;
        negative = 1'b1;
        return 1'b0;
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
        if (negative && b != CH_ZERO) return 1'b1;
        magnitude = magnitude * 10 + 64'(b - CH_ZERO);
        has_digit = 1'b1;
        return magnitude > limit;
      end
      return 1'b1;
    endfunction

    function byte_report_t predict_report(kind_t k, logic [7:0] b);
      byte_report_t r;
      bit           bad;
      err_code_t    code;
      r    = '0;
      bad  = 1'b0;
      code = ERR_ARRAY;
      if (k == KIND_RESYNC) begin
        clear_request();
        held = 1'b0;
        return r;
      end
      if (held) return r;
      r.argument_number = args_received;
      case (phase)
        PH_ARRAY: begin
          if (b == CH_STAR) begin
            clear_number();
            phase = PH_COUNT;
          end else begin
            bad = 1'b1; code = ERR_ARRAY;
          end
        end
        PH_COUNT: begin
          if (b == CH_CR) begin
            if (!has_digit || magnitude == 0) begin
              bad = 1'b1; code = ERR_COUNT;
            end else phase = PH_COUNT_LF;
          end else if (number_char_bad(b, 1'b1, {48'd0, max_args})) begin
            bad = 1'b1; code = ERR_COUNT;
          end
        end
        PH_COUNT_LF: begin
          if (b == CH_LF) begin
            args_expected = magnitude[15:0];
            args_received = '0;
            phase = PH_BULK;
          end else begin
            bad = 1'b1; code = ERR_COUNT;
          end
        end
        PH_BULK: begin
          if (b == CH_DOLLAR) begin
            clear_number();
            phase = PH_LEN;
          end else begin
            bad = 1'b1; code = ERR_BULK;
          end
        end
        PH_LEN: begin
          if (b == CH_CR) begin
            if (!has_digit) begin
              bad = 1'b1; code = ERR_LENGTH;
            end else phase = PH_LEN_LF;
          end else if (number_char_bad(b, 1'b0, {32'd0, max_bulk})) begin
            bad = 1'b1; code = ERR_LENGTH;
          end
        end
        PH_LEN_LF: begin
          if (b == CH_LF) begin
            cur_length = magnitude[31:0];
            remaining  = cur_length;
            phase = (remaining == 0) ? PH_DATA_CR : PH_DATA;
          end else begin
            bad = 1'b1; code = ERR_LENGTH;
          end
        end
        PH_DATA: begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          remaining = remaining - 32'd1;
          if (remaining == 0) phase = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (b == CH_CR) phase = PH_DATA_LF;
          else begin
            bad = 1'b1; code = ERR_TERM;
          end
        end
        PH_DATA_LF: begin
          if (b == CH_LF) begin
            r.argument_done   = 1'b1;
            r.argument_length = cur_length;
            args_received = args_received + 16'd1;
            if (args_received == args_expected) begin
              r.command_done   = 1'b1;
              r.argument_total = args_expected;
              clear_request();
            end else phase = PH_BULK;
          end else begin
            bad = 1'b1; code = ERR_TERM;
          end
        end
        default: begin
          bad = 1'b1; code = ERR_ARRAY;
        end
      endcase
      if (bad) begin
        r.error_flag = 1'b1;
        r.error_code = code;
        held = 1'b1;
      end
      return r;
    endfunction

    function void note_beat(kind_t k, logic [7:0] b);
      if (k == KIND_RESYNC || !held) live_beats++;
      awaited_reports.push_back(predict_report(k, b));
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h actual 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_beat(byte_report_t got);
      byte_report_t want;
      if (awaited_reports.size() == 0) begin
        $error("result beat with no report pending");
        failures++;
        return;
      end
      want = awaited_reports.pop_front();
      match_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
      match_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      match_field("argument_number", 32'(want.argument_number),
                  32'(got.argument_number));
      match_field("argument_done", 32'(want.argument_done), 32'(got.argument_done));
      match_field("argument_length", want.argument_length, got.argument_length);
      match_field("command_done", 32'(want.command_done), 32'(got.command_done));
      match_field("argument_total", 32'(want.argument_total), 32'(got.argument_total));
      match_field("error_flag", 32'(want.error_flag), 32'(got.error_flag));
      match_field("error_code", 32'(want.error_code), 32'(got.error_code));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_MAX_ARGS;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  kind_t       in_kind = KIND_BYTE;
  logic [7:0]  in_stream_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_argument_number;
  logic        out_argument_done;
  logic [31:0] out_argument_length;
  logic        out_command_done;
  logic [15:0] out_argument_total;
  logic        out_error_flag;
  logic [2:0]  out_error_code;

  parse_scoreboard sb;
  bit              tail_mode = 1'b0;
  int unsigned     in_calm = 0;
  int unsigned     ready_calm = 0;
  int unsigned     ready_stall = 0;

  resp_request_parser_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_stream_byte      (in_stream_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_valid   (out_payload_valid),
    .out_payload_byte    (out_payload_byte),
    .out_argument_number (out_argument_number),
    .out_argument_done   (out_argument_done),
    .out_argument_length (out_argument_length),
    .out_command_done    (out_command_done),
    .out_argument_total  (out_argument_total),
    .out_error_flag      (out_error_flag),
    .out_error_code      (out_error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stall bursts, calm stretches, none in the tail.
  always @(posedge clk) begin
    if (ready_stall > 0) begin
      ready_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (ready_calm > 0) ready_calm--;
      else if (!tail_mode) begin
        if ($urandom_range(0, 39) == 0) ready_calm = $urandom_range(30, 150);
        else if ($urandom_range(0, 7) == 0) ready_stall = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk) begin
    byte_report_t got;
    if (rst_n && out_valid && out_ready) begin
      got.payload_valid   = out_payload_valid;
      got.payload_byte    = out_payload_byte;
      got.argument_number = out_argument_number;
      got.argument_done   = out_argument_done;
      got.argument_length = out_argument_length;
      got.command_done    = out_command_done;
      got.argument_total  = out_argument_total;
      got.error_flag      = out_error_flag;
      got.error_code      = err_code_t'(out_error_code);
      sb.check_beat(got);
    end
  end

  // Offer one beat, with an optional gap first; return at the edge that takes it.
  task automatic push_item(input kind_t k, input logic [7:0] b);
    if (in_calm > 0) in_calm--;
    else if (!tail_mode) begin
      if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(30, 150);
      else if ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(k, b);
  endtask

  task automatic send_resync();
    push_item(KIND_RESYNC, 8'($urandom_range(0, 255)));
  endtask

  // Caret stands for CR and bar for LF in the directed texts.
  task automatic send_text(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c == "^") c = CH_CR;
      else if (c == "|") c = CH_LF;
      push_item(KIND_BYTE, c);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] args_lim, input logic [31:0] bulk_lim);
    logic [31:0] args_word;
    args_word = {16'($urandom), args_lim};
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ARGS;
    cfg_wdata <= args_word;
    @(posedge clk);
    sb.set_reg(CFG_MAX_ARGS, args_word);
    cfg_index <= CFG_MAX_BULK;
    cfg_wdata <= bulk_lim;
    @(posedge clk);
    sb.set_reg(CFG_MAX_BULK, bulk_lim);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_number(ref logic [7:0] q[$], input longint unsigned v,
                                     input bit is_len);
    string s;
    s = $sformatf("%0d", v);
    if (is_len && v == 0 && $urandom_range(0, 4) == 0) q.push_back(CH_MINUS);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) q.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // One request with random content; some are cut, corrupted or preceded by noise.
  task automatic send_random_request();
    logic [7:0]      req[$];
    longint unsigned lim, n, len;
    int unsigned     pick, shown, keep, idx;
    bit              cut_short;
    cut_short = 1'b0;
    if ($urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 3)) req.push_back(8'($urandom_range(0, 255)));
    lim  = 64'(sb.max_args);
    pick = $urandom_range(0, 19);
    if (pick == 0) n = lim + 1;
    else if (pick == 1 && lim != 0) n = lim;
    else n = 64'($urandom_range((lim == 0) ? 32'd0 : 32'd1, (lim < 4) ? 32'(lim) : 32'd4));
    req.push_back(CH_STAR);
    add_number(req, n, 1'b0);
    req.push_back(CH_CR);
    req.push_back(CH_LF);
    shown = (n > 5) ? 32'd5 : 32'(n);
    for (int a = 0; a < shown && !cut_short; a++) begin
      lim  = 64'(sb.max_bulk);
      pick = $urandom_range(0, 14);
      if (pick == 0) len = lim + 1;
      else if (pick == 1) len = lim;
      else len = 64'($urandom_range(0, (lim < 6) ? 32'(lim) : 32'd6));
      req.push_back(CH_DOLLAR);
      add_number(req, len, 1'b1);
      req.push_back(CH_CR);
      req.push_back(CH_LF);
      if (len > 10) begin
        len = 10;
        cut_short = 1'b1;
      end
      repeat (len) req.push_back(8'($urandom_range(0, 255)));
      if (!cut_short) begin
        req.push_back(CH_CR);
        req.push_back(CH_LF);
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      idx = $urandom_range(0, req.size() - 1);
      case ($urandom_range(0, 7))
        0: req.delete(idx);
        1: req[idx] = CH_MINUS;
        2: req[idx] = CH_CR;
        3: req[idx] = CH_LF;
        4: req[idx] = 8'(CH_ZERO + $urandom_range(0, 9));
        5: req[idx] = CH_STAR;
        6: req[idx] = CH_DOLLAR;
        default: req[idx] = 8'($urandom_range(0, 255));
      endcase
    end else if ($urandom_range(0, 11) == 0 && req.size() > 1) begin
      keep = $urandom_range(1, req.size() - 1);
      while (req.size() > keep) void'(req.pop_back());
    end
    foreach (req[i]) begin
      push_item(KIND_BYTE, req[i]);
      if (sb.held) break;
    end
    if (sb.held)
      repeat ($urandom_range(0, 3)) push_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    if (sb.held || sb.phase != PH_ARRAY || $urandom_range(0, 9) == 0) send_resync();
  endtask

  task automatic run_random(input int unsigned beats);
    int unsigned target;
    target = sb.live_beats + beats;
    while (sb.live_beats < target) send_random_request();
  endtask

  task automatic run_texts(input string texts[]);
    foreach (texts[i]) begin
      send_text(texts[i]);
      send_resync();
    end
  endtask

  initial begin
    string       basics[];
    string       extremes[];
    int unsigned settle;
    basics = '{
      "*1^|$3^|abc^|*002^|$-00^|^|$1^|*^|",
      "*2^|$0^|^|$-0^|^|",
      "x",
      "*0^|",
      "*-1",
      "*^",
      "*1025",
      "*1x",
      "*1^X",
      "*1^|#",
      "*1^|$-1",
      "*1^|$--",
      "*1^|$0-",
      "*1^|$^",
      "*1^|$536870913",
      "*1^|$1^X",
      "*1^|$1^|ab",
      "*1^|$1^|a^X",
      "*2^|$1^|a^|",
      "*1^|$4^|^|$*^|",
      "*1x$$$^|",
      "*1024^|$536870912^|zz"
    };
    extremes = '{
      "*65535^|$4294967295^|ab",
      "*065536",
      "*1^|$04294967296",
      "*1^|$4294967295^|^"
    };
    sb = new();
    sb.power_on();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    run_texts(basics);
    apply_setting(16'hFFFF, 32'hFFFF_FFFF);
    run_texts(extremes);
    run_random(350);
    apply_setting(16'd1, 32'd0);
    run_random(230);
    apply_setting(16'd0, 32'd7);
    run_random(50);
    apply_setting(16'd3, 32'd5);
    run_random(350);
    apply_setting(16'd6, 32'd12);
    run_random(410);
    tail_mode = 1'b1;
    run_random(110);

    in_valid <= 1'b0;
    settle = 0;
    while (sb.awaited_reports.size() != 0 && settle < 2000) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (sb.awaited_reports.size() != 0) begin
      $error("%0d report beats never arrived", sb.awaited_reports.size());
      sb.failures++;
    end
    if (sb.failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
